>>> src/xcrc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xcrc_pkg
// Shared types, character codes and the CRC-16 byte step for the
// XMODEM-CRC receiver.
// ----------------------------------------------------------------------------
package xcrc_pkg;

  localparam int DATA_LEN = 128;

  localparam logic [7:0] CH_SOH    = 8'h01;
  localparam logic [7:0] CH_EOT    = 8'h04;
  localparam logic [7:0] CH_ACK    = 8'h06;
  localparam logic [7:0] CH_NAK    = 8'h15;
  localparam logic [7:0] CH_CAN    = 8'h18;
  localparam logic [7:0] CH_PAD    = 8'h1A;
  localparam logic [7:0] CH_POKE   = 8'h43;
  localparam logic [7:0] CH_BREAK  = 8'h42;
  localparam logic [7:0] CH_BREAKL = 8'h62;

  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam logic [9:0] POKE_LIMIT_RESET = 10'd1000;

  // Frame byte positions
  localparam logic [7:0] IDX_BLOCK    = 8'd0;
  localparam logic [7:0] IDX_COMPL    = 8'd1;
  localparam logic [7:0] IDX_CRC_HIGH = 8'(2 + DATA_LEN);

  // Configuration register indexes
  localparam logic CFG_START_ADDRESS = 1'b0;
  localparam logic CFG_POKE_LIMIT    = 1'b1;

  // End-of-transfer status codes
  localparam logic [1:0] ST_SUCCESS     = 2'd0;
  localparam logic [1:0] ST_TIMEOUT     = 2'd1;
  localparam logic [1:0] ST_USER_CANCEL = 2'd2;
  localparam logic [1:0] ST_SEND_CANCEL = 2'd3;

  typedef enum logic [3:0] {
    PH_START  = 4'b0001,
    PH_FRAME  = 4'b0010,
    PH_HEADER = 4'b0100,
    PH_DONE   = 4'b1000
  } phase_t;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        data_valid;
    logic [7:0]  data_byte;
    logic [31:0] data_address;
    logic        frame_good;
    logic        frame_bad;
    logic        finished;
    logic [1:0]  status;
    logic [31:0] byte_total;
    logic        last;
  } result_t;

  // One byte through the CCITT CRC, MSB first.
  function automatic logic [15:0] crc_step(input logic [15:0] crc_in,
                                           input logic [7:0] data);
    logic [15:0] crc;
    crc = crc_in ^ {data, 8'h00};
    for (int b = 0; b < 8; b++) begin
      if (crc[15]) begin
        crc = {crc[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        crc = {crc[14:0], 1'b0};
      end
    end
    return crc;
  endfunction

endpackage
`default_nettype wire

>>> src/xmodem_crc_receiver_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xmodem_crc_receiver_top
// Receive side of an XMODEM-CRC transfer: start pokes, frame checks, data out.
// ----------------------------------------------------------------------------
// Each result beat is written into the result queue and read out in order.
// Throughput: one input beat per cycle while in_stall is low; an EOT gives two result beats.
// Input stall is set by the fill of a three-entry result queue (two or more
// entries waiting), so a stalled output backs up the queue and then holds off the input.
// Reset (rst, synchronous) clears the protocol state, empties the queue and
// loads start_address = 0 and poke_limit = 1000.
module xmodem_crc_receiver_top (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration write port
  input  wire logic        cfg_write,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        kind,
  input  wire logic [7:0]  rx_byte,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             tx_valid,
  output logic [7:0]       tx_byte,
  output logic             data_valid,
  output logic [7:0]       data_byte,
  output logic [31:0]      data_address,
  output logic             frame_good,
  output logic             frame_bad,
  output logic             finished,
  output logic [1:0]       status,
  output logic [31:0]      byte_total,
  output logic             last
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [31:0] start_address;
  logic [9:0]  poke_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_address <= '0;
      poke_limit    <= xcrc_pkg::POKE_LIMIT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        xcrc_pkg::CFG_START_ADDRESS: start_address <= cfg_data;
        xcrc_pkg::CFG_POKE_LIMIT:    poke_limit    <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Protocol state
  // --------------------------------------------------------------------------
  xcrc_pkg::phase_t phase, phase_next;
  logic [7:0]  frame_index, frame_index_next;
  logic [7:0]  block_byte, block_byte_next;
  logic [7:0]  block_complement, block_complement_next;
  logic [15:0] crc_running, crc_running_next;
  logic [7:0]  crc_high_received, crc_high_received_next;
  logic [7:0]  expected_block, expected_block_next;
  logic [31:0] address_offset, address_offset_next;
  logic [9:0]  poke_count, poke_count_next;
  logic [7:0]  frame_nonpad, frame_nonpad_next;
  logic [31:0] committed_total, committed_total_next;

  // Result queue: three entries, two may be pushed in one beat
  xcrc_pkg::result_t queue [3];
  logic [1:0] rd_ptr, wr_ptr, count;
  logic [1:0] push_count;
  xcrc_pkg::result_t res0, res1;

  logic in_accept, out_accept;
  logic timeout;
  logic [7:0] c;
  logic frame_ok;
  logic [31:0] pos;

  assign in_stall   = (count >= 2'd2);
  assign in_accept  = in_valid && !in_stall;
  assign out_valid  = (count != 2'd0);
  assign out_accept = out_valid && !out_stall;

  // A timeout inside a frame counts as a zero byte.
  assign timeout = kind;
  assign c       = kind ? 8'h00 : rx_byte;
  assign pos     = {24'h0, frame_index} - 32'd2;

  assign frame_ok = (block_byte == expected_block) &&
                    (block_complement == ~block_byte) &&
                    ({crc_high_received, c} == crc_running);

  function automatic logic [1:0] wrap3(input logic [1:0] p);
    return (p == 2'd2) ? 2'd0 : p + 2'd1;
  endfunction

  // --------------------------------------------------------------------------
  // Next state and result beats for one input beat
  // --------------------------------------------------------------------------
  always_comb begin
    phase_next             = phase;
    frame_index_next       = frame_index;
    block_byte_next        = block_byte;
    block_complement_next  = block_complement;
    crc_running_next       = crc_running;
    crc_high_received_next = crc_high_received;
    expected_block_next    = expected_block;
    address_offset_next    = address_offset;
    poke_count_next        = poke_count;
    frame_nonpad_next      = frame_nonpad;
    committed_total_next   = committed_total;
    res0       = '0;
    res1       = '0;
    push_count = 2'd0;

    case (phase)
      xcrc_pkg::PH_START, xcrc_pkg::PH_HEADER: begin
        if (timeout) begin
          // Poke only while waiting to start; drop timeouts between frames.
          if (phase == xcrc_pkg::PH_START) begin
            push_count      = 2'd1;
            res0.tx_valid   = 1'b1;
            res0.tx_byte    = xcrc_pkg::CH_POKE;
            poke_count_next = poke_count + 10'd1;
            if (poke_count_next >= poke_limit) begin
              res0.finished = 1'b1;
              res0.status   = xcrc_pkg::ST_TIMEOUT;
              phase_next    = xcrc_pkg::PH_DONE;
            end
          end
        end else if (phase == xcrc_pkg::PH_START &&
                     (c == xcrc_pkg::CH_BREAK || c == xcrc_pkg::CH_BREAKL)) begin
          push_count    = 2'd1;
          res0.finished = 1'b1;
          res0.status   = xcrc_pkg::ST_USER_CANCEL;
          phase_next    = xcrc_pkg::PH_DONE;
        end else if (c == xcrc_pkg::CH_SOH) begin
          // Open a frame: clear per-frame bookkeeping.
          phase_next             = xcrc_pkg::PH_FRAME;
          frame_index_next       = '0;
          block_byte_next        = '0;
          block_complement_next  = '0;
          crc_running_next       = '0;
          crc_high_received_next = '0;
          frame_nonpad_next      = '0;
        end else begin
          // Echo every other byte outside a frame.
          push_count    = 2'd1;
          res0.tx_valid = 1'b1;
          res0.tx_byte  = c;
          if (c == xcrc_pkg::CH_EOT) begin
            push_count    = 2'd2;
            res1.tx_valid = 1'b1;
            res1.tx_byte  = xcrc_pkg::CH_ACK;
            res1.finished = 1'b1;
            res1.status   = xcrc_pkg::ST_SUCCESS;
            phase_next    = xcrc_pkg::PH_DONE;
          end else if (c == xcrc_pkg::CH_CAN) begin
            res0.finished = 1'b1;
            res0.status   = xcrc_pkg::ST_SEND_CANCEL;
            phase_next    = xcrc_pkg::PH_DONE;
          end else begin
            phase_next      = xcrc_pkg::PH_START;
            poke_count_next = '0;
          end
        end
      end
      xcrc_pkg::PH_FRAME: begin
        frame_index_next = frame_index + 8'd1;
        if (frame_index == xcrc_pkg::IDX_BLOCK) begin
          block_byte_next = c;
        end else if (frame_index == xcrc_pkg::IDX_COMPL) begin
          block_complement_next = c;
        end else if (frame_index < xcrc_pkg::IDX_CRC_HIGH) begin
          push_count        = 2'd1;
          res0.data_valid   = 1'b1;
          res0.data_byte    = c;
          res0.data_address = start_address + address_offset + pos;
          crc_running_next  = xcrc_pkg::crc_step(crc_running, c);
          if (c != xcrc_pkg::CH_PAD) begin
            frame_nonpad_next = frame_nonpad + 8'd1;
          end
        end else if (frame_index == xcrc_pkg::IDX_CRC_HIGH) begin
          crc_high_received_next = c;
        end else begin
          // Last CRC byte closes the frame: commit or discard it.
          if (frame_ok) begin
            committed_total_next = committed_total + {24'h0, frame_nonpad};
            expected_block_next  = expected_block + 8'd1;
            address_offset_next  = address_offset + 32'(xcrc_pkg::DATA_LEN);
          end
          push_count      = 2'd1;
          res0.tx_valid   = 1'b1;
          res0.tx_byte    = frame_ok ? xcrc_pkg::CH_ACK : xcrc_pkg::CH_NAK;
          res0.frame_good = frame_ok;
          res0.frame_bad  = !frame_ok;
          phase_next      = xcrc_pkg::PH_HEADER;
        end
      end
      default: ;
    endcase

    res0.byte_total = committed_total_next;
    res1.byte_total = committed_total_next;
    res0.last       = (push_count == 2'd1);
    res1.last       = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= xcrc_pkg::PH_START;
      frame_index       <= '0;
      block_byte        <= '0;
      block_complement  <= '0;
      crc_running       <= '0;
      crc_high_received <= '0;
      expected_block    <= 8'd1;
      address_offset    <= '0;
      poke_count        <= '0;
      frame_nonpad      <= '0;
      committed_total   <= '0;
    end else if (in_accept) begin
      phase             <= phase_next;
      frame_index       <= frame_index_next;
      block_byte        <= block_byte_next;
      block_complement  <= block_complement_next;
      crc_running       <= crc_running_next;
      crc_high_received <= crc_high_received_next;
      expected_block    <= expected_block_next;
      address_offset    <= address_offset_next;
      poke_count        <= poke_count_next;
      frame_nonpad      <= frame_nonpad_next;
      committed_total   <= committed_total_next;
    end
  end

  // --------------------------------------------------------------------------
  // Result queue: push the beats of an accepted input, pop on output accept
  // --------------------------------------------------------------------------
  logic [1:0] pushed, popped;
  assign pushed = in_accept ? push_count : 2'd0;
  assign popped = out_accept ? 2'd1 : 2'd0;

  always_ff @(posedge clk) begin
    if (pushed != 2'd0) begin
      queue[wr_ptr] <= res0;
    end
    if (pushed == 2'd2) begin
      queue[wrap3(wr_ptr)] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count + pushed - popped;
      if (out_accept) begin
        rd_ptr <= wrap3(rd_ptr);
      end
      if (pushed == 2'd1) begin
        wr_ptr <= wrap3(wr_ptr);
      end else if (pushed == 2'd2) begin
        wr_ptr <= wrap3(wrap3(wr_ptr));
      end
    end
  end

  // Drive the head of the queue onto the result ports.
  assign tx_valid     = queue[rd_ptr].tx_valid;
  assign tx_byte      = queue[rd_ptr].tx_byte;
  assign data_valid   = queue[rd_ptr].data_valid;
  assign data_byte    = queue[rd_ptr].data_byte;
  assign data_address = queue[rd_ptr].data_address;
  assign frame_good   = queue[rd_ptr].frame_good;
  assign frame_bad    = queue[rd_ptr].frame_bad;
  assign finished     = queue[rd_ptr].finished;
  assign status       = queue[rd_ptr].status;
  assign byte_total   = queue[rd_ptr].byte_total;
  assign last         = queue[rd_ptr].last;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    in_accept |-> ({1'b0, count} + {1'b0, push_count} <= 3'd3))
    else $error("result queue overflow");

  a_done_silent: assert property (@(posedge clk) disable iff (rst)
    (phase == xcrc_pkg::PH_DONE) |-> (push_count == 2'd0))
    else $error("result produced after the transfer ended");

  a_done_sticks: assert property (@(posedge clk) disable iff (rst)
    (phase == xcrc_pkg::PH_DONE) |=> (phase == xcrc_pkg::PH_DONE))
    else $error("left the finished phase without reset");

  a_finish_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && finished) |-> last)
    else $error("finishing beat not marked last");

  a_good_bad_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(frame_good && frame_bad))
    else $error("frame both committed and discarded");

endmodule
`default_nettype wire

>>> test/testbench.sv
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the XMODEM-CRC receiver. A beat generator walks the
// protocol (start pokes, stray bytes, good and damaged frames, one closing
// event) and runs a beat-by-beat model of the receiver as it queues each beat.
// A driver plays the beats out in bursts. A monitor checks every result beat,
// field by field, against the model's replies.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int LONG_HOLD   = 400;

  typedef struct packed {
    logic       kind;
    logic [7:0] value;
  } line_beat_t;

  // How a generated frame is damaged, and what its payload looks like.
  typedef enum {
    FR_GOOD, FR_DUPLICATE, FR_WRONG_BLOCK, FR_BAD_COMPLEMENT, FR_BAD_CRC
  } frame_fault_t;
  typedef enum {BODY_RANDOM, BODY_PADDED, BODY_SPECIAL, BODY_EXTREME} frame_body_t;
  // How the single transfer of the run is brought to an end.
  typedef enum {END_EOT, END_SENDER_CANCEL, END_USER_CANCEL, END_POKES} wrapup_t;

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic        cfg_index = 1'b0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        kind = 1'b0;
  logic [7:0]  rx_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        tx_valid;
  logic [7:0]  tx_byte;
  logic        data_valid;
  logic [7:0]  data_byte;
  logic [31:0] data_address;
  logic        frame_good;
  logic        frame_bad;
  logic        finished;
  logic [1:0]  status;
  logic [31:0] byte_total;
  logic        last;

  always #6 clk = ~clk;

  xmodem_crc_receiver_top DUT (.*);

  // --------------------------------------------------------------------------
  // Receiver model state and its copy of the registers
  // --------------------------------------------------------------------------
  xcrc_pkg::phase_t rx_phase = xcrc_pkg::PH_START;
  logic [7:0]  frame_pos = '0;
  logic [7:0]  blk_num = '0;
  logic [7:0]  blk_inv = '0;
  logic [15:0] crc_acc = '0;
  logic [7:0]  crc_hi = '0;
  logic [7:0]  next_block = 8'd1;
  logic [31:0] addr_offset = '0;
  logic [9:0]  poke_cnt = '0;
  logic [7:0]  frame_pad_free = '0;
  logic [31:0] total_committed = '0;
  logic [31:0] cfg_start = '0;
  logic [9:0]  cfg_poke_limit = xcrc_pkg::POKE_LIMIT_RESET;

  xcrc_pkg::result_t expected_replies[$];
  line_beat_t  rx_line[$];
  int          beats_sent = 0;
  int          errors = 0;
  int          hold_asked = 0;
  int          hold_served = 0;
  int          cycle_count = 0;

  // CCITT CRC-16, one data bit at a time, MSB first.
  function automatic logic [15:0] crc16_byte(input logic [15:0] acc, input logic [7:0] d);
    logic [15:0] c;
    c = acc;
    for (int i = 7; i >= 0; i--) begin
      if (c[15] ^ d[i]) begin
        c = {c[14:0], 1'b0} ^ xcrc_pkg::CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  // Every reply carries the running committed count; everything else starts at zero.
  function automatic xcrc_pkg::result_t blank_reply();
    xcrc_pkg::result_t r;
    r = '0;
    r.byte_total = total_committed;
    return r;
  endfunction

  task automatic open_frame();
    rx_phase       = xcrc_pkg::PH_FRAME;
    frame_pos      = '0;
    blk_num        = '0;
    blk_inv        = '0;
    crc_acc        = '0;
    crc_hi         = '0;
    frame_pad_free = '0;
  endtask

  // Non-SOH byte between frames: echo it, then EOT, CAN or back to the start.
  task automatic outside_byte(input logic [7:0] c);
    xcrc_pkg::result_t r;
    r = blank_reply();
    r.tx_valid = 1'b1;
    r.tx_byte  = c;
    if (c == xcrc_pkg::CH_EOT) begin
      expected_replies.push_back(r);
      r = blank_reply();
      r.tx_valid = 1'b1;
      r.tx_byte  = xcrc_pkg::CH_ACK;
      r.finished = 1'b1;
      r.status   = xcrc_pkg::ST_SUCCESS;
      rx_phase   = xcrc_pkg::PH_DONE;
    end else if (c == xcrc_pkg::CH_CAN) begin
      r.finished = 1'b1;
      r.status   = xcrc_pkg::ST_SEND_CANCEL;
      rx_phase   = xcrc_pkg::PH_DONE;
    end else begin
      rx_phase = xcrc_pkg::PH_START;
      poke_cnt = '0;
    end
    expected_replies.push_back(r);
  endtask

  // Advance the model by one input beat and queue the replies it causes.
  task automatic advance_receiver(input logic k, input logic [7:0] b);
    logic [7:0]        c;
    logic              good;
    int                size_prior;
    xcrc_pkg::result_t r;
    size_prior = expected_replies.size();
    c = k ? 8'h00 : b;
    case (rx_phase)
      xcrc_pkg::PH_START: begin
        if (k) begin
          r = blank_reply();
          r.tx_valid = 1'b1;
          r.tx_byte  = xcrc_pkg::CH_POKE;
          poke_cnt   = poke_cnt + 10'd1;
          if (poke_cnt >= cfg_poke_limit) begin
            r.finished = 1'b1;
            r.status   = xcrc_pkg::ST_TIMEOUT;
            rx_phase   = xcrc_pkg::PH_DONE;
          end
          expected_replies.push_back(r);
        end else if (c == xcrc_pkg::CH_BREAK || c == xcrc_pkg::CH_BREAKL) begin
          r = blank_reply();
          r.finished = 1'b1;
          r.status   = xcrc_pkg::ST_USER_CANCEL;
          rx_phase   = xcrc_pkg::PH_DONE;
          expected_replies.push_back(r);
        end else if (c == xcrc_pkg::CH_SOH) begin
          open_frame();
        end else begin
          outside_byte(c);
        end
      end
      xcrc_pkg::PH_HEADER: begin
        if (!k) begin
          if (c == xcrc_pkg::CH_SOH) begin
            open_frame();
          end else begin
            outside_byte(c);
          end
        end
      end
      xcrc_pkg::PH_FRAME: begin
        if (frame_pos == xcrc_pkg::IDX_BLOCK) begin
          blk_num = c;
        end else if (frame_pos == xcrc_pkg::IDX_COMPL) begin
          blk_inv = c;
        end else if (frame_pos < xcrc_pkg::IDX_CRC_HIGH) begin
          r = blank_reply();
          r.data_valid   = 1'b1;
          r.data_byte    = c;
          r.data_address = cfg_start + addr_offset +
                           32'(frame_pos - xcrc_pkg::IDX_COMPL - 8'd1);
          crc_acc = crc16_byte(crc_acc, c);
          if (c != xcrc_pkg::CH_PAD) begin
            frame_pad_free = frame_pad_free + 8'd1;
          end
          expected_replies.push_back(r);
        end else if (frame_pos == xcrc_pkg::IDX_CRC_HIGH) begin
          crc_hi = c;
        end else begin
          good = (blk_num == next_block) && (blk_inv == ~blk_num) && ({crc_hi, c} == crc_acc);
          if (good) begin
            total_committed = total_committed + 32'(frame_pad_free);
            next_block      = next_block + 8'd1;
            addr_offset     = addr_offset + 32'(xcrc_pkg::DATA_LEN);
          end
          r = blank_reply();
          r.tx_valid   = 1'b1;
          r.tx_byte    = good ? xcrc_pkg::CH_ACK : xcrc_pkg::CH_NAK;
          r.frame_good = good;
          r.frame_bad  = !good;
          rx_phase     = xcrc_pkg::PH_HEADER;
          expected_replies.push_back(r);
        end
        frame_pos = frame_pos + 8'd1;
      end
      default: begin
      end
    endcase
    // Mark the closing reply of this beat.
    if (expected_replies.size() > size_prior) begin
      r = expected_replies.pop_back();
      r.last = 1'b1;
      expected_replies.push_back(r);
    end
  endtask

  // --------------------------------------------------------------------------
  // Beat generation
  // --------------------------------------------------------------------------
  task automatic send_beat(input logic k, input logic [7:0] b);
    line_beat_t beat;
    beat.kind  = k;
    beat.value = b;
    // Beats the receiver drops (after the transfer ends, or timeouts between frames) are not counted.
    if (rx_phase != xcrc_pkg::PH_DONE && !(rx_phase == xcrc_pkg::PH_HEADER && k)) begin
      beats_sent++;
    end
    rx_line.push_back(beat);
    advance_receiver(k, b);
  endtask

  // One random beat that cannot close the transfer.
  task automatic noise_beat();
    logic [7:0] b;
    logic       may_poke;
    may_poke = (rx_phase == xcrc_pkg::PH_HEADER) ||
               (rx_phase == xcrc_pkg::PH_START &&
                int'(poke_cnt) + 1 < int'(cfg_poke_limit));
    if (rx_phase == xcrc_pkg::PH_FRAME || rx_phase == xcrc_pkg::PH_DONE) begin
      send_beat($urandom_range(0, 4) == 0, 8'($urandom));
    end else if (may_poke && $urandom_range(0, 2) == 0) begin
      send_beat(1'b1, 8'($urandom));
    end else begin
      do begin
        b = 8'($urandom);
      end while (b == xcrc_pkg::CH_EOT || b == xcrc_pkg::CH_CAN ||
                 (rx_phase == xcrc_pkg::PH_START &&
                  (b == xcrc_pkg::CH_BREAK || b == xcrc_pkg::CH_BREAKL)));
      send_beat(1'b0, b);
    end
  endtask

  function automatic frame_fault_t pick_fault();
    case ($urandom_range(0, 9))
      6:       return FR_DUPLICATE;
      7:       return FR_WRONG_BLOCK;
      8:       return FR_BAD_COMPLEMENT;
      9:       return FR_BAD_CRC;
      default: return FR_GOOD;
    endcase
  endfunction

  function automatic frame_body_t pick_body();
    return frame_body_t'($urandom_range(0, 3));
  endfunction

  function automatic logic [7:0] special_byte();
    case ($urandom_range(0, 8))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return xcrc_pkg::CH_PAD;
      3:       return xcrc_pkg::CH_SOH;
      4:       return xcrc_pkg::CH_EOT;
      5:       return xcrc_pkg::CH_CAN;
      6:       return xcrc_pkg::CH_BREAK;
      7:       return xcrc_pkg::CH_BREAKL;
      default: return 8'($urandom);
    endcase
  endfunction

  // SOH plus a full frame; zero bytes go out as timeouts now and then.
  task automatic send_frame(input frame_fault_t fault, input frame_body_t body_kind);
    logic [7:0]  body [0:131];
    logic [15:0] crc;
    int          cut;
    // Finish any frame that noise has opened.
    while (rx_phase == xcrc_pkg::PH_FRAME) begin
      noise_beat();
    end
    crc = '0;
    cut = $urandom_range(0, xcrc_pkg::DATA_LEN);
    for (int i = 0; i < xcrc_pkg::DATA_LEN; i++) begin
      case (body_kind)
        BODY_RANDOM:  body[i + 2] = 8'($urandom);
        BODY_PADDED:  body[i + 2] = (i < cut) ? 8'($urandom) : xcrc_pkg::CH_PAD;
        BODY_SPECIAL: body[i + 2] = special_byte();
        default:      body[i + 2] = i[0] ? 8'h00 : 8'hFF;
      endcase
      crc = crc16_byte(crc, body[i + 2]);
    end
    body[0] = next_block;
    case (fault)
      FR_DUPLICATE:   body[0] = next_block - 8'd1;
      FR_WRONG_BLOCK: body[0] = 8'($urandom);
      FR_BAD_CRC:     crc = crc ^ (16'd1 << $urandom_range(0, 15));
      default: begin
      end
    endcase
    body[1] = ~body[0];
    if (fault == FR_BAD_COMPLEMENT) begin
      body[1] = body[1] ^ (8'd1 << $urandom_range(0, 7));
    end
    body[130] = crc[15:8];
    body[131] = crc[7:0];
    send_beat(1'b0, xcrc_pkg::CH_SOH);
    for (int i = 0; i < 132; i++) begin
      if (body[i] == 8'h00 && $urandom_range(0, 3) == 0) begin
        send_beat(1'b1, 8'($urandom));
      end else begin
        send_beat(1'b0, body[i]);
      end
    end
  endtask

  task automatic random_phase(input int beats);
    int stop;
    stop = beats_sent + beats;
    while (beats_sent < stop) begin
      if ($urandom_range(0, 9) < 6) begin
        send_frame(pick_fault(), pick_body());
      end else begin
        repeat ($urandom_range(1, 6)) noise_beat();
      end
    end
  endtask

  // Hold off new beats until the line is empty and every reply has come back.
  task automatic wait_drained();
    while (rx_line.size() != 0 || in_valid || expected_replies.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    if (idx == xcrc_pkg::CFG_START_ADDRESS) begin
      cfg_start = value;
    end else begin
      cfg_poke_limit = value[9:0];
    end
  endtask

  // Ask the result-side stall process for one long stall stretch.
  task automatic request_hold();
    @(posedge clk);
    hold_asked++;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus sequence: one transfer per run, since reset comes only once
  // --------------------------------------------------------------------------
  initial begin : stimulus
    wrapup_t wrapup;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: pokes, stray bytes, zero byte, frames of each kind, header timeouts.
    send_beat(1'b1, 8'hFF);
    send_beat(1'b1, 8'h00);
    send_beat(1'b0, 8'h00);
    send_beat(1'b0, 8'hFF);
    send_beat(1'b1, 8'h5A);
    send_beat(1'b0, 8'h80);
    send_beat(1'b1, 8'h00);
    send_frame(FR_GOOD, BODY_SPECIAL);
    send_beat(1'b1, 8'hA5);
    send_beat(1'b0, xcrc_pkg::CH_BREAKL);
    send_beat(1'b1, 8'h00);
    send_frame(FR_DUPLICATE, BODY_EXTREME);
    send_beat(1'b1, 8'hFF);
    send_frame(FR_GOOD, BODY_PADDED);
    send_frame(FR_BAD_CRC, BODY_RANDOM);
    send_frame(FR_BAD_COMPLEMENT, BODY_RANDOM);
    send_frame(FR_WRONG_BLOCK, BODY_EXTREME);
    send_frame(FR_GOOD, BODY_EXTREME);
    wait_drained();

    // Random start address, widest poke limit; stall the output long enough
    // that the block backs up and stalls its input.
    write_reg(xcrc_pkg::CFG_START_ADDRESS, $urandom);
    write_reg(xcrc_pkg::CFG_POKE_LIMIT, 32'd1023);
    send_frame(FR_GOOD, BODY_RANDOM);
    request_hold();
    random_phase(100);
    wait_drained();

    // Top of the address space, so addresses wrap; a poke limit of one.
    write_reg(xcrc_pkg::CFG_START_ADDRESS, 32'hFFFF_FFFF);
    write_reg(xcrc_pkg::CFG_POKE_LIMIT, 32'd1);
    random_phase(100);
    wait_drained();

    write_reg(xcrc_pkg::CFG_START_ADDRESS, 32'h0000_0000);
    write_reg(xcrc_pkg::CFG_POKE_LIMIT, $urandom_range(2, 1022));
    random_phase(100);
    wait_drained();

    // Start address near the top again, with a second long hold on the output.
    write_reg(xcrc_pkg::CFG_START_ADDRESS, $urandom | 32'hFFFF_0000);
    request_hold();

    // Close the transfer one way, then show that later beats are dropped.
    wrapup = wrapup_t'($urandom_range(0, 3));
    case (wrapup)
      END_EOT: begin
        while (rx_phase == xcrc_pkg::PH_FRAME) noise_beat();
        send_beat(1'b0, xcrc_pkg::CH_EOT);
      end
      END_SENDER_CANCEL: begin
        while (rx_phase == xcrc_pkg::PH_FRAME) noise_beat();
        send_beat(1'b0, xcrc_pkg::CH_CAN);
      end
      END_USER_CANCEL: begin
        while (rx_phase != xcrc_pkg::PH_START) noise_beat();
        send_beat(1'b0, $urandom_range(0, 1) ? xcrc_pkg::CH_BREAK : xcrc_pkg::CH_BREAKL);
      end
      default: begin
        while (rx_phase != xcrc_pkg::PH_START) noise_beat();
        wait_drained();
        write_reg(xcrc_pkg::CFG_POKE_LIMIT, $urandom_range(1, 6));
        while (rx_phase != xcrc_pkg::PH_DONE) send_beat(1'b1, 8'($urandom));
      end
    endcase
    repeat (16) send_beat(1'($urandom_range(0, 1)), 8'($urandom));

    wait_drained();
    repeat (16) @(posedge clk);
    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Driver: play beats out in bursts, hold a stalled beat steady
  // --------------------------------------------------------------------------
  logic       beat_accepted = 1'b0;
  int         burst_left = 0;
  int         gap_left = 0;
  line_beat_t next_beat;

  always @(posedge clk) begin
    beat_accepted <= !rst && in_valid && !in_stall;
  end

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || beat_accepted) begin
      if (gap_left > 0 || rx_line.size() == 0) begin
        in_valid <= 1'b0;
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end
      end else begin
        next_beat = rx_line.pop_front();
        in_valid <= 1'b1;
        kind     <= next_beat.kind;
        rx_byte  <= next_beat.value;
        // End of a burst: pick the next burst length and the gap before it.
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 64);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result side stall: switch among stall patterns, serve long holds on request
  // --------------------------------------------------------------------------
  int         hold_left = 0;
  int         stall_mode = 0;
  int         mode_left = 0;
  logic [7:0] stall_ring = 8'b1100_1010;

  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_asked) begin
      hold_served <= hold_served + 1;
      hold_left   <= LONG_HOLD;
      out_stall   <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left  <= $urandom_range(8, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 1) == 0);
        2: out_stall <= ($urandom_range(0, 4) == 0);
        default: begin
          out_stall  <= stall_ring[7];
          stall_ring <= {stall_ring[6:0], stall_ring[7]};
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: compare each result beat with the oldest reply still owed
  // --------------------------------------------------------------------------
  xcrc_pkg::result_t want;

  task automatic check_field(input string name, input logic [31:0] exp_val,
                             input logic [31:0] got_val);
    if (got_val !== exp_val) begin
      $error("%s: expected %0h, got %0h", name, exp_val, got_val);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_replies.size() == 0) begin
        $error("result beat with no reply owed");
        errors++;
      end else begin
        want = expected_replies.pop_front();
        check_field("tx_valid", 32'(want.tx_valid), 32'(tx_valid));
        check_field("tx_byte", 32'(want.tx_byte), 32'(tx_byte));
        check_field("data_valid", 32'(want.data_valid), 32'(data_valid));
        check_field("data_byte", 32'(want.data_byte), 32'(data_byte));
        check_field("data_address", want.data_address, data_address);
        check_field("frame_good", 32'(want.frame_good), 32'(frame_good));
        check_field("frame_bad", 32'(want.frame_bad), 32'(frame_bad));
        check_field("finished", 32'(want.finished), 32'(finished));
        check_field("status", 32'(want.status), 32'(status));
        check_field("byte_total", want.byte_total, byte_total);
        check_field("last", 32'(want.last), 32'(last));
      end
    end
  end

  // Drop the run if it hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

endmodule
`default_nettype wire

>>> sim.f
src/xcrc_pkg.sv
src/xmodem_crc_receiver_top.sv
test/testbench.sv
